@@ rtl/core/mdrc_pkg.sv @@
// Package for the mono downmix rate converter.
// Shared widths, constants, register map and the phase unit result type.
// No dependencies.
`timescale 1ns / 1ps

package mdrc_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 19;
    localparam int PHASE_W  = 20;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Fixed output rate and per-frame result cap
    localparam logic [PHASE_W-1:0] OUTPUT_RATE = PHASE_W'(48000);
    localparam int MAX_RESULTS = 64;
    localparam int COUNT_W     = $clog2(MAX_RESULTS);

    // Register reset values
    localparam logic [RATE_W-1:0] SOURCE_RATE_RST = RATE_W'(48000);

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_SOURCE_RATE  = 2'd0;
    localparam logic [1:0] REG_TWO_CHANNELS = 2'd1;
    localparam logic [1:0] REG_WIDE_SAMPLES = 2'd2;

    // Result of one pass through the phase unit
    typedef struct packed {
        logic               below;  // phase below OUTPUT_RATE: emit a beat
        logic               wraps;  // stepped phase reaches OUTPUT_RATE
        logic [PHASE_W-1:0] value;  // stepped phase
    } t_ph_res;

endpackage

@@ rtl/core/mdrc_decode.sv @@
// Sample decoder: turns one raw source frame into a signed 16-bit mono sample.
// Depends on mdrc_pkg.
`timescale 1ns / 1ps

module mdrc_decode
    import mdrc_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_first_channel,
    input  logic [SAMPLE_W-1:0] i_second_channel,
    input  logic                i_two_channels,
    input  logic                i_wide_samples,
    output logic [SAMPLE_W-1:0] o_mono
);

    logic signed [SAMPLE_W:0]   first_dec;
    logic signed [SAMPLE_W:0]   second_dec;
    logic signed [SAMPLE_W+1:0] sum;
    logic signed [SAMPLE_W+1:0] half;

    // Wide: sign-extend. Narrow: low byte minus 128, scaled by 256.
    always_comb begin
        if (i_wide_samples) begin
            first_dec  = {i_first_channel[SAMPLE_W-1], i_first_channel};
            second_dec = {i_second_channel[SAMPLE_W-1], i_second_channel};
        end else begin
            first_dec  = {~i_first_channel[7], ~i_first_channel[7],
                          i_first_channel[6:0], 8'h00};
            second_dec = {~i_second_channel[7], ~i_second_channel[7],
                          i_second_channel[6:0], 8'h00};
        end
    end

    // Average both channels, rounding toward zero
    always_comb begin
        sum  = {first_dec[SAMPLE_W], first_dec} + {second_dec[SAMPLE_W], second_dec};
        half = (sum + {{(SAMPLE_W+1){1'b0}}, sum[SAMPLE_W+1]}) >>> 1;
    end

    assign o_mono = i_two_channels ? half[SAMPLE_W-1:0] : first_dec[SAMPLE_W-1:0];

endmodule

@@ rtl/core/mdrc_phase_unit.sv @@
// Shared phase unit: one adder that either advances the phase by the source
// rate or takes OUTPUT_RATE off it, plus the compares. Depends on mdrc_pkg.
`timescale 1ns / 1ps

module mdrc_phase_unit
    import mdrc_pkg::*;
(
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [RATE_W-1:0]  i_source_rate,
    output t_ph_res            o_res
);

    logic               below;
    logic [PHASE_W-1:0] operand;
    logic [PHASE_W-1:0] stepped;

    // Pick addend: source rate while emitting, minus OUTPUT_RATE at the end
    always_comb begin
        below   = i_phase < OUTPUT_RATE;
        operand = below ? {1'b0, i_source_rate} : (~OUTPUT_RATE + PHASE_W'(1));
        stepped = i_phase + operand;
    end

    assign o_res.below = below;
    assign o_res.wraps = stepped >= OUTPUT_RATE;
    assign o_res.value = stepped;

endmodule

@@ rtl/core/mono_downmix_rate_converter.sv @@
// Mono downmix rate converter top level: register port, sequencer, output stage.
// Depends on mdrc_pkg, mdrc_decode and mdrc_phase_unit.
`timescale 1ns / 1ps

// Takes one source frame per input beat (mono or stereo, 8-bit unsigned or
// 16-bit signed), downmixes it to one signed 16-bit sample and sends out every
// 48 kHz output frame whose nearest earlier source frame is this one, the same
// sample on left and right, run_last marking the final beat of the frame.
// A frame keeps the input stalled from the moment it is accepted until the phase
// leaves it: a shared phase unit steps the phase accumulator once per cycle while
// the output side does not stall, one output beat per step, plus one step to
// rebase the phase.
// At most 64 beats come from one frame; when the cap cuts a frame short the
// phase restarts at zero and no rebase step is needed.
// track_start clears the phase before its frame. Program the registers only
// while the block is idle.
module mono_downmix_rate_converter
    import mdrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // source frames
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_first_channel,
    input  logic [SAMPLE_W-1:0] i_second_channel,
    input  logic                i_track_start,
    // output frames
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_left_out,
    output logic [SAMPLE_W-1:0] o_right_out,
    output logic                o_run_last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                r_state;
    logic [RATE_W-1:0]   r_source_rate;
    logic                r_two_channels;
    logic                r_wide_samples;
    logic [PHASE_W-1:0]  r_phase;
    logic [SAMPLE_W-1:0] r_held;
    logic [COUNT_W-1:0]  r_count;
    logic                r_ovalid;
    logic [SAMPLE_W-1:0] r_osample;
    logic                r_olast;

    logic                cfg_wr;
    logic                in_take;
    logic                out_free;
    logic                emit;
    logic                cap_hit;
    logic [SAMPLE_W-1:0] mono;
    t_ph_res             ph_res;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_rate  <= SOURCE_RATE_RST;
            r_two_channels <= 1'b1;
            r_wide_samples <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SOURCE_RATE:  r_source_rate  <= pwdata[RATE_W-1:0];
                REG_TWO_CHANNELS: r_two_channels <= pwdata[0];
                REG_WIDE_SAMPLES: r_wide_samples <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SOURCE_RATE:  prdata = {{(DATA_W-RATE_W){1'b0}}, r_source_rate};
            REG_TWO_CHANNELS: prdata = {{(DATA_W-1){1'b0}}, r_two_channels};
            REG_WIDE_SAMPLES: prdata = {{(DATA_W-1){1'b0}}, r_wide_samples};
            default:          prdata = '0;
        endcase
    end

    // Datapath units
    mdrc_decode u_decode (
        .i_first_channel  (i_first_channel),
        .i_second_channel (i_second_channel),
        .i_two_channels   (r_two_channels),
        .i_wide_samples   (r_wide_samples),
        .o_mono           (mono)
    );

    mdrc_phase_unit u_phase (
        .i_phase       (r_phase),
        .i_source_rate (r_source_rate),
        .o_res         (ph_res)
    );

    // Handshake terms
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid & ~o_stall;
    assign out_free = ~r_ovalid | ~i_stall;
    assign emit     = (r_state == S_RUN) & ph_res.below & out_free;
    assign cap_hit  = (r_count == COUNT_W'(MAX_RESULTS - 1));

    // Sequencer: step the phase once per cycle while the output can take a beat, until it leaves this frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_held  <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_held  <= mono;
                        r_count <= '0;
                        if (i_track_start) begin
                            r_phase <= '0;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!ph_res.below) begin
                        // rebase phase onto the next frame
                        r_phase <= ph_res.value;
                        r_state <= S_IDLE;
                    end else if (emit) begin
                        r_count <= r_count + COUNT_W'(1);
                        if (cap_hit && !ph_res.wraps) begin
                            // drop the rest of this frame
                            r_phase <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_phase <= ph_res.value;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_osample <= r_held;
            r_olast   <= ph_res.wraps | cap_hit;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_left_out  = r_osample;
    assign o_right_out = r_osample;
    assign o_run_last  = r_olast;

endmodule

@@ rtl/core/mdrc_checker.sv @@
// Port-level checker for the mono downmix rate converter, bound to the top.
// Depends on mdrc_pkg and mono_downmix_rate_converter.
`timescale 1ns / 1ps

module mdrc_checker
    import mdrc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [SAMPLE_W-1:0] o_left_out,
    input logic [SAMPLE_W-1:0] o_right_out,
    input logic                o_run_last
);

    // Both output channels carry the same mono sample
    a_dup_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_out == o_right_out))
        else $error("left and right samples differ");

    // An accepted frame stalls the input in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a frame was taken");

    // Once idle, any pending output beat closes the previous frame
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && o_valid) |-> o_run_last)
        else $error("block idle with a frame still open");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_left_out) && $stable(o_run_last)))
        else $error("stalled output beat changed");

endmodule

bind mono_downmix_rate_converter mdrc_checker u_mdrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_left_out  (o_left_out),
    .o_right_out (o_right_out),
    .o_run_last  (o_run_last)
);

@@ verif/tb_mono_downmix_rate_converter.sv @@
`timescale 1ns / 1ps
// Testbench for mono_downmix_rate_converter: a directed frame table, then random frames
// over several register settings, every output beat checked against a built-in predictor.
// Depends on mdrc_pkg and the block's RTL only.

module tb_mono_downmix_rate_converter;
    import mdrc_pkg::*;

    localparam int SETTLE   = 16;         // cycles the block may still be busy after its last beat
    localparam int MAX_WAIT = 16;         // longest idle draw on either side
    localparam int LIMIT    = 1_000_000;  // cycle budget for the whole run

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                last;
    } beat_t;

    typedef struct packed {
        logic [RATE_W-1:0]   rate;
        logic                stereo;
        logic                wide;
        logic [SAMPLE_W-1:0] first;
        logic [SAMPLE_W-1:0] second;
        logic                track;
        logic                known;   // sample typed into the row
        logic [SAMPLE_W-1:0] sample;
    } frame_row_t;

    logic                i_clk;
    logic                i_rst_n          = 1'b0;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [ADDR_W-1:0]   paddr            = '0;
    logic [DATA_W-1:0]   pwdata           = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid          = 1'b0;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_first_channel  = '0;
    logic [SAMPLE_W-1:0] i_second_channel = '0;
    logic                i_track_start    = 1'b0;
    logic                o_valid;
    logic                i_stall          = 1'b0;
    logic [SAMPLE_W-1:0] o_left_out;
    logic [SAMPLE_W-1:0] o_right_out;
    logic                o_run_last;

    // Predictor copy of registers and state
    logic [RATE_W-1:0]   cfg_rate   = SOURCE_RATE_RST;
    logic                cfg_stereo = 1'b1;
    logic                cfg_wide   = 1'b1;
    logic [PHASE_W-1:0]  phase_acc  = '0;
    logic [SAMPLE_W-1:0] held_smp   = '0;

    beat_t      due_beats[$];
    beat_t      want_beat;
    frame_row_t directed_rows[$];
    bit         quiet       = 1'b0;
    int         err_count   = 0;
    int         cycle_count = 0;

    mono_downmix_rate_converter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_channel  (i_first_channel),
        .i_second_channel (i_second_channel),
        .i_track_start    (i_track_start),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_run_last       (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Decode one channel field to a signed sample
    function automatic int decode_chan(input logic [SAMPLE_W-1:0] raw);
        if (cfg_wide)
            return int'($signed(raw));
        return (int'(raw[7:0]) - 128) * 256;
    endfunction

    // Downmix one accepted frame and queue every 48 kHz beat it owns
    task automatic resample_frame(input frame_row_t fr);
        int          mono;
        int unsigned ph;
        int unsigned lim;
        int          n;
        beat_t       b;
        lim = 32'(OUTPUT_RATE);
        if (fr.track)
            phase_acc = '0;
        mono = decode_chan(fr.first);
        if (cfg_stereo)
            mono = (mono + decode_chan(fr.second)) / 2;
        held_smp = mono[SAMPLE_W-1:0];
        b.left   = fr.known ? fr.sample : held_smp;
        b.right  = b.left;
        ph = 32'(phase_acc);
        n  = 0;
        while (ph < lim && n < MAX_RESULTS) begin
            ph += 32'(cfg_rate);
            n++;
            b.last = !(ph < lim && n < MAX_RESULTS);
            due_beats.push_back(b);
        end
        // rebase, or restart at zero when the cap cut the frame short
        ph = (ph >= lim) ? ph - lim : 32'd0;
        phase_acc = ph[PHASE_W-1:0];
    endtask

    task automatic add_row(input int rate, input int stereo, input int wide,
                           input logic [15:0] first, input logic [15:0] second,
                           input int track, input int known, input logic [15:0] sample);
        frame_row_t r;
        r.rate   = rate[RATE_W-1:0];
        r.stereo = stereo[0];
        r.wide   = wide[0];
        r.first  = first;
        r.second = second;
        r.track  = track[0];
        r.known  = known[0];
        r.sample = sample;
        directed_rows.push_back(r);
    endtask

    // Drop valid, wait until every beat is back, then let the block settle
    task automatic wait_idle(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Setup phase, access phase held until pready, then the bus goes idle
    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SOURCE_RATE:  cfg_rate   = val[RATE_W-1:0];
            REG_TWO_CHANNELS: cfg_stereo = val[0];
            REG_WIDE_SAMPLES: cfg_wide   = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [RATE_W-1:0] rate, input logic stereo,
                                input logic wide);
        if (rate == cfg_rate && stereo == cfg_stereo && wide == cfg_wide)
            return;
        wait_idle(SETTLE);
        if (rate != cfg_rate)
            reg_write(REG_SOURCE_RATE, DATA_W'(rate));
        if (stereo != cfg_stereo)
            reg_write(REG_TWO_CHANNELS, DATA_W'(stereo));
        if (wide != cfg_wide)
            reg_write(REG_WIDE_SAMPLES, DATA_W'(wide));
    endtask

    // Idle for a random gap, present the frame, hold it until accepted
    task automatic send_frame(input frame_row_t fr);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_first_channel  <= fr.first;
        i_second_channel <= fr.second;
        i_track_start    <= fr.track;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        resample_frame(fr);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: stall a random number of cycles before each beat
    initial begin : out_side
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Compare every accepted beat with the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_beats.size() == 0) begin
                $display("%0t: beat with none due: left %0d right %0d last %0b", $time,
                         $signed(o_left_out), $signed(o_right_out), o_run_last);
                err_count++;
            end else begin
                want_beat = due_beats.pop_front();
                if (o_left_out !== want_beat.left) begin
                    $display("%0t: left_out expected %0d actual %0d", $time,
                             $signed(want_beat.left), $signed(o_left_out));
                    err_count++;
                end
                if (o_right_out !== want_beat.right) begin
                    $display("%0t: right_out expected %0d actual %0d", $time,
                             $signed(want_beat.right), $signed(o_right_out));
                    err_count++;
                end
                if (o_run_last !== want_beat.last) begin
                    $display("%0t: run_last expected %0b actual %0b", $time,
                             want_beat.last, o_run_last);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        frame_row_t        fr;
        logic [RATE_W-1:0] ph_rate;
        logic              ph_stereo;
        logic              ph_wide;
        int                n_items;

        // stereo 16-bit at the output rate: one beat per frame, extremes and rounding
        add_row(48000, 1, 1, 16'h0000, 16'h0000, 1, 1, 16'h0000);
        add_row(48000, 1, 1, 16'h7FFF, 16'h7FFF, 0, 1, 16'h7FFF);
        add_row(48000, 1, 1, 16'h8000, 16'h8000, 0, 1, 16'h8000);
        add_row(48000, 1, 1, 16'h7FFF, 16'h8000, 0, 1, 16'h0000);
        add_row(48000, 1, 1, 16'h8000, 16'h0001, 0, 1, 16'hC001);
        add_row(48000, 1, 1, 16'hFFFF, 16'h0000, 0, 1, 16'h0000);
        add_row(48000, 1, 1, 16'hFFFF, 16'hFFFF, 0, 1, 16'hFFFF);
        // mono ignores the second channel
        add_row(48000, 0, 1, 16'h1234, 16'hFFFF, 0, 1, 16'h1234);
        add_row(48000, 0, 1, 16'h8000, 16'h7FFF, 0, 1, 16'h8000);
        // 8-bit unsigned ignores the high byte
        add_row(48000, 0, 0, 16'h00FF, 16'h0000, 0, 1, 16'h7F00);
        add_row(48000, 0, 0, 16'hFF00, 16'h1234, 0, 1, 16'h8000);
        add_row(48000, 0, 0, 16'hAB80, 16'h0000, 0, 1, 16'h0000);
        add_row(48000, 1, 0, 16'h00FF, 16'h00FF, 0, 1, 16'h7F00);
        add_row(48000, 1, 0, 16'hFF00, 16'hAA00, 0, 1, 16'h8000);
        add_row(48000, 1, 0, 16'h0000, 16'h00FF, 0, 1, 16'hFF80);
        // zero rate hits the cap; 750 Hz fills it exactly; 700 Hz overruns it
        add_row(0,      1, 1, 16'h0100, 16'h0300, 0, 1, 16'h0200);
        add_row(750,    1, 1, 16'h4000, 16'h0000, 0, 1, 16'h2000);
        add_row(700,    1, 1, 16'h0002, 16'h0004, 0, 1, 16'h0003);
        // fastest rates: mostly frames with no beat, track start restores one
        add_row(524287, 1, 1, 16'h0010, 16'h0020, 1, 1, 16'h0018);
        add_row(524287, 1, 1, 16'h0000, 16'h0000, 0, 0, 16'h0000);
        add_row(524287, 1, 1, 16'h1111, 16'h2222, 0, 0, 16'h0000);
        add_row(524287, 1, 1, 16'h5555, 16'hAAAA, 1, 1, 16'h0000);
        add_row(384000, 1, 1, 16'h7FFF, 16'h7FFF, 1, 1, 16'h7FFF);
        add_row(384000, 1, 1, 16'h8000, 16'h8000, 0, 0, 16'h0000);
        add_row(24000,  1, 1, 16'h0123, 16'h0123, 1, 1, 16'h0123);

        // hold reset low, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            fr = directed_rows[k];
            apply_config(fr.rate, fr.stereo, fr.wide);
            send_frame(fr);
        end

        // random frames, one register setting per phase
        for (int p = 0; p < 11; p++) begin
            ph_rate   = RATE_W'(48000);
            ph_stereo = 1'b1;
            ph_wide   = 1'b1;
            case (p)
                1: begin ph_rate = RATE_W'(44100);  ph_stereo = 1'b0; end
                2: begin ph_rate = RATE_W'(8000);   ph_wide   = 1'b0; end
                3: begin ph_rate = RATE_W'(96000);  ph_stereo = 1'b0; ph_wide = 1'b0; end
                4: ph_rate = '0;
                5: begin ph_rate = RATE_W'(750);    ph_stereo = 1'b0; ph_wide = 1'b0; end
                6: ph_rate = RATE_W'(524287);
                7: begin ph_rate = RATE_W'(384000); ph_stereo = 1'b0; end
                8: ph_rate = RATE_W'(22050);
                9: begin
                    ph_rate   = RATE_W'($urandom_range(750, 384000));
                    ph_stereo = 1'($urandom_range(0, 1));
                    ph_wide   = 1'($urandom_range(0, 1));
                end
                10: begin ph_rate = RATE_W'(11025); ph_wide = 1'b0; end
                default: ;
            endcase
            apply_config(ph_rate, ph_stereo, ph_wide);
            quiet   = (p == 2 || p == 7);
            n_items = (p == 4 || p == 5) ? 4 : 15;
            for (int k = 0; k < n_items; k++) begin
                // once, starve the input until the output has caught up
                if (p == 3 && k == 9)
                    wait_idle(0);
                fr.rate   = ph_rate;
                fr.stereo = ph_stereo;
                fr.wide   = ph_wide;
                fr.first  = pick_sample();
                fr.second = pick_sample();
                fr.track  = ($urandom_range(0, 7) == 0);
                fr.known  = 1'b0;
                fr.sample = '0;
                send_frame(fr);
            end
        end

        quiet = 1'b0;
        wait_idle(SETTLE);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mdrc_pkg.sv
rtl/core/mdrc_decode.sv
rtl/core/mdrc_phase_unit.sv
rtl/core/mono_downmix_rate_converter.sv
rtl/core/mdrc_checker.sv
verif/tb_mono_downmix_rate_converter.sv
